@@ hw/rtl/sbms_pkg.sv @@
// ----------------------------------------------------------------------------
// sbms_pkg
// Shared types and constants for the saturation bucket max-select block.
// ----------------------------------------------------------------------------
package sbms_pkg;

    localparam int MAX_COLORS      = 32;
    localparam int MAX_DEGREE_ROWS = 64;
    localparam int COUNT_WIDTH     = 16;

    // store is banked by flat index mod MAX_COLORS, so any degree row
    // (at most MAX_COLORS wide) touches each bank at most once
    localparam int NUM_BANKS   = MAX_COLORS;
    localparam int BANK_W      = $clog2(NUM_BANKS);
    localparam int LINES       = MAX_DEGREE_ROWS;
    localparam int LINE_W      = $clog2(LINES);
    localparam int STORE_DEPTH = NUM_BANKS * LINES;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam int COLOR_W = 5;
    localparam int DEG_W   = 6;
    localparam int NC_W    = 6;
    localparam int NR_W    = 7;
    localparam int CFG_W   = 7;

    localparam int GROUP      = 8;
    localparam int NUM_GROUPS = NUM_BANKS / GROUP;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic CFG_COLORS = 1'b0;
    localparam logic CFG_ROWS   = 1'b1;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] cnt;
        logic [BANK_W-1:0]      col;
    } t_cand;

    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic ins_calc;
        logic ins_rd;
        logic ins_wr;
        logic q_init;
        logic q_issue;
        logic flush;
        logic res_hit;
        logic res_miss;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic q_empty;
        logic issue_last;
        logic hit;
        logic scan_idle;
        logic out_free;
    } t_sts;

    // larger count wins, ties to the lower color
    function automatic t_cand pick(input t_cand a, input t_cand b);
        if ((a.cnt > b.cnt) || ((a.cnt == b.cnt) && (a.col < b.col))) begin
            return a;
        end
        return b;
    endfunction

endpackage

@@ hw/rtl/saturation_bucket_max_select.sv @@
// ----------------------------------------------------------------------------
// saturation_bucket_max_select
// Occupancy grid of (color, degree) buckets with best-bucket query.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the count store
// with o_s_tready low. An insert (tuser 0) runs address multiply, bank
// read and saturating write between accept and the next tready. A query
// (tuser 1) scans degree rows from the top, one row of up to 32 counts per
// cycle read in parallel from 32 store banks, and stops at the first row
// with a nonempty bucket; when either config register is zero it reports
// not found without a scan. The result waits to be loaded while the
// previous result is still held on the output. Each row passes through
// the single read port per bank and a two-stage registered max tree. The
// output register lets inserts proceed while a result waits on i_m_tready.
module saturation_bucket_max_select (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [4:0] color, [10:5] degree, [15:11] zero
    input  logic        i_s_tuser,   // [0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [10:0] best_index, [26:11] best_count, [31:27] zero
    output logic        o_m_tuser,   // [0] found
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import sbms_pkg::*;

    t_cmd                   cmd;
    t_sts                   sts;
    logic [IDX_W-1:0]       best_index;
    logic [COUNT_WIDTH-1:0] best_count;

    sbms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_opcode   (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sbms_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_color      (i_s_tdata[COLOR_W-1:0]),
        .i_degree     (i_s_tdata[COLOR_W+DEG_W-1:COLOR_W]),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_found      (o_m_tuser),
        .o_best_index (best_index),
        .o_best_count (best_count)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {5'd0, best_count, best_index};

endmodule

@@ hw/rtl/sbms_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbms_ctrl
// Sequencer: clearing pass, insert read-modify-write, query row scan.
// ----------------------------------------------------------------------------
module sbms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_opcode,
    output logic           o_s_tready,
    input  sbms_pkg::t_sts i_sts,
    output sbms_pkg::t_cmd o_cmd
);
    import sbms_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_CALC,
        ST_INS_RD,
        ST_INS_WR,
        ST_Q_INIT,
        ST_Q_SCAN,
        ST_Q_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_s_tready;
    logic   r_issued_all, n_issued_all;

    always_comb begin
        n_state      = r_state;
        n_issued_all = r_issued_all;
        o_cmd        = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid && r_s_tready) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_opcode == OP_QUERY) ? ST_Q_INIT : ST_INS_CALC;
                end
            end
            ST_INS_CALC: begin
                o_cmd.ins_calc = 1'b1;
                n_state = ST_INS_RD;
            end
            ST_INS_RD: begin
                o_cmd.ins_rd = 1'b1;
                n_state = ST_INS_WR;
            end
            ST_INS_WR: begin
                o_cmd.ins_wr = 1'b1;
                n_state = ST_IDLE;
            end
            ST_Q_INIT: begin
                if (i_sts.q_empty) begin
                    o_cmd.res_miss = 1'b1;
                    n_state = ST_Q_OUT;
                end else begin
                    o_cmd.q_init = 1'b1;
                    n_issued_all = 1'b0;
                    n_state = ST_Q_SCAN;
                end
            end
            ST_Q_SCAN: begin
                if (i_sts.hit) begin
                    // first row with a nonempty bucket; drop lower rows in flight
                    o_cmd.res_hit = 1'b1;
                    o_cmd.flush   = 1'b1;
                    n_state = ST_Q_OUT;
                end else if (r_issued_all && i_sts.scan_idle) begin
                    o_cmd.res_miss = 1'b1;
                    n_state = ST_Q_OUT;
                end else if (!r_issued_all) begin
                    o_cmd.q_issue = 1'b1;
                    if (i_sts.issue_last) begin
                        n_issued_all = 1'b1;
                    end
                end
            end
            ST_Q_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_s_tready   <= 1'b0;
            r_issued_all <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_s_tready   <= (n_state == ST_IDLE);
            r_issued_all <= n_issued_all;
        end
    end

    assign o_s_tready = r_s_tready;

endmodule

@@ hw/rtl/sbms_dp.sv @@
// ----------------------------------------------------------------------------
// sbms_dp
// Datapath: banked count store, config registers, row reduction pipeline,
// result and output registers.
// ----------------------------------------------------------------------------
module sbms_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sbms_pkg::t_cmd                   i_cmd,
    output sbms_pkg::t_sts                   o_sts,
    input  logic [sbms_pkg::COLOR_W-1:0]     i_color,
    input  logic [sbms_pkg::DEG_W-1:0]       i_degree,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_index,
    input  logic [sbms_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic                             o_found,
    output logic [sbms_pkg::IDX_W-1:0]       o_best_index,
    output logic [sbms_pkg::COUNT_WIDTH-1:0] o_best_count
);
    import sbms_pkg::*;

    // configuration
    logic [NC_W-1:0] r_colors;
    logic [NR_W-1:0] r_rows;
    logic [NC_W-1:0] eff_nc;
    logic [NR_W-1:0] eff_nr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colors <= NC_W'(MAX_COLORS);
            r_rows   <= NR_W'(MAX_DEGREE_ROWS);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COLORS: r_colors <= i_cfg_data[NC_W-1:0];
                CFG_ROWS:   r_rows   <= i_cfg_data[NR_W-1:0];
                default:    r_rows   <= r_rows;
            endcase
        end
    end

    assign eff_nc = (r_colors > NC_W'(MAX_COLORS)) ? NC_W'(MAX_COLORS) : r_colors;
    assign eff_nr = (r_rows > NR_W'(MAX_DEGREE_ROWS)) ? NR_W'(MAX_DEGREE_ROWS) : r_rows;

    // captured request
    logic [COLOR_W-1:0] r_color;
    logic [DEG_W-1:0]   r_degree;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_color  <= i_color;
            r_degree <= i_degree;
        end
    end

    // clearing pass line counter
    logic [LINE_W-1:0] r_clr_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_line <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_line <= r_clr_line + 1'b1;
        end
    end

    // insert address
    logic [IDX_W-1:0]   r_ins_idx;
    logic               r_ins_ok;
    logic [2*NC_W-1:0]  ins_prod;

    assign ins_prod = NC_W'(r_degree) * eff_nc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_calc) begin
            r_ins_idx <= ins_prod[IDX_W-1:0] + IDX_W'(r_color);
            r_ins_ok  <= (NC_W'(r_color) < eff_nc) && (NR_W'(r_degree) < eff_nr);
        end
    end

    // query row pointer: base flat index of the row and rows left
    logic [IDX_W-1:0]  r_base;
    logic [DEG_W-1:0]  r_row;
    logic [DEG_W-1:0]  top_row;
    logic [2*NC_W-1:0] top_prod;

    assign top_row  = DEG_W'(eff_nr - 1'b1);
    assign top_prod = NC_W'(top_row) * eff_nc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_init) begin
            r_base <= top_prod[IDX_W-1:0];
            r_row  <= top_row;
        end else if (i_cmd.q_issue) begin
            r_base <= r_base - IDX_W'(eff_nc);
            r_row  <= r_row - 1'b1;
        end
    end

    // banked store
    logic [COUNT_WIDTH-1:0] r_mem     [NUM_BANKS][LINES];
    logic [COUNT_WIDTH-1:0] r_rd_data [NUM_BANKS];
    logic [LINE_W-1:0]      rd_addr   [NUM_BANKS];
    logic [LINE_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic [COUNT_WIDTH-1:0] ins_old;
    logic                   rd_en;
    logic                   ins_we;

    assign rd_en   = i_cmd.ins_rd || i_cmd.q_issue;
    assign ins_old = r_rd_data[r_ins_idx[BANK_W-1:0]];
    assign ins_we  = i_cmd.ins_wr && r_ins_ok && (ins_old != CNT_MAX);
    assign wr_addr = i_cmd.clr_wr ? r_clr_line : r_ins_idx[IDX_W-1:BANK_W];
    assign wr_data = i_cmd.clr_wr ? '0 : (ins_old + 1'b1);

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        // a row starting at offset o wraps into the next line for banks below o
        always_comb begin
            if (i_cmd.ins_rd) begin
                rd_addr[b] = r_ins_idx[IDX_W-1:BANK_W];
            end else if (BANK_W'(b) >= r_base[BANK_W-1:0]) begin
                rd_addr[b] = r_base[IDX_W-1:BANK_W];
            end else begin
                rd_addr[b] = r_base[IDX_W-1:BANK_W] + 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.clr_wr || (ins_we && (r_ins_idx[BANK_W-1:0] == BANK_W'(b)))) begin
                r_mem[b][wr_addr] <= wr_data;
            end
            if (rd_en) begin
                r_rd_data[b] <= r_mem[b][rd_addr[b]];
            end
        end
    end

    // reduction pipeline: stage 1 tag travels with the read data
    logic              r_t1_v;
    logic [IDX_W-1:0]  r_t1_base;
    logic              r_t2_v;
    logic [IDX_W-1:0]  r_t2_base;
    t_cand             r_t2_cand [NUM_GROUPS];
    t_cand             grp_win   [NUM_GROUPS];
    t_cand             row_win;

    always_comb begin
        t_cand             c;
        logic [BANK_W-1:0] col;
        int                b;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_win[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                b     = g * GROUP + k;
                col   = BANK_W'(b) - r_t1_base[BANK_W-1:0];
                c.col = col;
                c.cnt = (NC_W'(col) < eff_nc) ? r_rd_data[b] : '0;
                grp_win[g] = (k == 0) ? c : pick(grp_win[g], c);
            end
        end
    end

    always_comb begin
        row_win = r_t2_cand[0];
        for (int g = 1; g < NUM_GROUPS; g++) begin
            row_win = pick(row_win, r_t2_cand[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.flush) begin
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
        end else begin
            r_t1_v <= i_cmd.q_issue;
            r_t2_v <= r_t1_v;
        end
        if (i_cmd.q_issue) begin
            r_t1_base <= r_base;
        end
        if (r_t1_v) begin
            r_t2_base <= r_t1_base;
            r_t2_cand <= grp_win;
        end
    end

    // result and output registers
    logic                   r_res_found;
    logic [IDX_W-1:0]       r_res_idx;
    logic [COUNT_WIDTH-1:0] r_res_cnt;
    logic                   r_out_v;
    logic                   r_out_found;
    logic [IDX_W-1:0]       r_out_idx;
    logic [COUNT_WIDTH-1:0] r_out_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_hit) begin
            r_res_found <= 1'b1;
            r_res_idx   <= r_t2_base + IDX_W'(row_win.col);
            r_res_cnt   <= row_win.cnt;
        end else if (i_cmd.res_miss) begin
            r_res_found <= 1'b0;
            r_res_idx   <= '0;
            r_res_cnt   <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_idx;
            r_out_cnt   <= r_res_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_found      = r_out_found;
    assign o_best_index = r_out_idx;
    assign o_best_count = r_out_cnt;

    assign o_sts.clr_last   = (r_clr_line == LINE_W'(LINES - 1));
    assign o_sts.q_empty    = (eff_nr == '0) || (eff_nc == '0);
    assign o_sts.issue_last = (r_row == '0);
    assign o_sts.hit        = r_t2_v && (row_win.cnt != '0);
    assign o_sts.scan_idle  = !r_t1_v && !r_t2_v;
    assign o_sts.out_free   = !r_out_v || i_m_tready;

endmodule

@@ hw/rtl/sbms_chk.sv @@
// ----------------------------------------------------------------------------
// sbms_chk
// Port-level checks for the bucket max-select block.
// ----------------------------------------------------------------------------
module sbms_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser
);

    // clearing pass holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("request ready during clearing pass");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready right after an accepted request");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 32'd0))
        else $error("not-found result with nonzero payload");

    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[26:11] != 16'd0))
        else $error("found result with empty bucket");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind saturation_bucket_max_select sbms_chk u_sbms_chk (.*);
